>>> rtl/core/shamh_pkg.sv
// Package for the SHA-256 message hasher: types, round constants and the
// Sigma/sigma helper functions. No dependencies.
`default_nettype none
package shamh_pkg;

   localparam int BLOCK_BYTES = 64;
   localparam int QUEUE_DEPTH = 4;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        last_word;
   } req_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LOAD,
      BK_ROUND,
      BK_FOLD,
      BK_EMIT
   } bk_state_type;

   localparam word_type INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/shamh_queue.sv
// Short request queue between the front end and the compression back end.
// Depends on shamh_pkg.
`default_nettype none
module shamh_queue
   import shamh_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_valid,
   output logic         wr_ready,
   input  wire req_type wr_data,
   output logic         rd_valid,
   input  wire logic    rd_ready,
   output req_type      rd_data
);
   localparam int AW = $clog2(QUEUE_DEPTH);

   req_type         mem_ff [QUEUE_DEPTH];
   logic [AW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]     cnt_ff, cnt_in;
   logic            push, pop;

   assign wr_ready = (cnt_ff != (AW+1)'(QUEUE_DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem_ff[rp_ff];
   assign push     = wr_valid & wr_ready;
   assign pop      = rd_valid & rd_ready;

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= wr_data;
   end
endmodule
`default_nettype wire

>>> rtl/core/shamh_front.sv
// Front end: takes message words, clamps the byte count and hands requests
// to the queue. Depends on shamh_pkg.
`default_nettype none
module shamh_front
   import shamh_pkg::*;
(
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_data_word,
   input  wire logic [2:0]  req_byte_count,
   input  wire logic        req_last_word,
   output logic             q_valid,
   input  wire logic        q_ready,
   output req_type          q_data
);
   assign q_valid   = req_valid;
   assign req_ready = q_ready;

   always_comb begin
      q_data.data_word  = req_data_word;
      q_data.byte_count = (req_byte_count > 3'd4) ? 3'd4 : req_byte_count;
      q_data.last_word  = req_last_word;
   end
endmodule
`default_nettype wire

>>> rtl/core/shamh_back.sv
// Back end: byte packing, padding, 64-round compression and digest output.
// Depends on shamh_pkg.
`default_nettype none
module shamh_back
   import shamh_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   output logic             q_ready,
   input  wire req_type     q_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_digest
);
   localparam logic [5:0] POS_LAST = 6'(BLOCK_BYTES - 1);
   localparam logic [5:0] POS_LEN  = 6'(BLOCK_BYTES - 8);

   bk_state_type   st_ff, st_in;
   word_type       h_ff [8];
   word_type       v_ff [8];
   word_type       w_ff [16];
   logic [5:0]     pos_ff;
   logic [63:0]    bits_ff;
   logic [6:0]     rnd_ff;
   logic [2:0]     nb_ff;     // bytes of the current request still to pack
   logic [2:0]     bi_ff;     // next byte within the word
   logic [31:0]    dw_ff;
   logic           last_ff;
   logic           pad_ff;    // in padding phase
   logic           lenblk_ff; // current compression is the final one
   logic [2:0]     oi_ff;

   word_type t1, t2, wnew, wcur;
   logic [7:0] cur_byte;
   logic       ld_byte, ld_zero, ld_mark;

   // message schedule kept as a 16-word sliding window
   always_comb begin
      wnew = small_sigma1(w_ff[14]) + w_ff[9] + small_sigma0(w_ff[1]) + w_ff[0];
      wcur = (rnd_ff < 7'd16) ? w_ff[rnd_ff[3:0]] : wnew;
      t1 = v_ff[7] + big_sigma1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + ROUND_K[rnd_ff[5:0]] + wcur;
      t2 = big_sigma0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2])
         ^ (v_ff[1] & v_ff[2]));
      cur_byte = dw_ff[5'(31 - 8*bi_ff) -: 8];
      ld_byte  = (nb_ff != '0);
      ld_zero  = pad_ff && !(pos_ff == POS_LEN && !lenblk_ff);
      ld_mark  = last_ff && !pad_ff;
   end

   assign q_ready         = (st_ff == BK_IDLE);
   assign rsp_valid       = (st_ff == BK_EMIT);
   assign rsp_digest_word = h_ff[oi_ff];
   assign rsp_word_index  = oi_ff;
   assign rsp_last_digest = (oi_ff == 3'd7);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         BK_IDLE:  if (q_valid) st_in = BK_LOAD;
         BK_LOAD: begin
            if (ld_byte || ld_zero || ld_mark) begin
               if (pos_ff == POS_LAST) st_in = BK_ROUND;
            end else begin
               st_in = pad_ff ? BK_ROUND : BK_IDLE;
            end
         end
         BK_ROUND: if (rnd_ff == 7'd63) st_in = BK_FOLD;
         BK_FOLD:  st_in = lenblk_ff ? BK_EMIT : BK_LOAD;
         BK_EMIT:  if (rsp_ready && oi_ff == 3'd7) st_in = BK_IDLE;
         default:  st_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= BK_IDLE;
         pos_ff  <= '0;
         bits_ff <= '0;
         oi_ff   <= '0;
         pad_ff  <= 1'b0;
         lenblk_ff <= 1'b0;
         for (int i = 0; i < 8; i++) h_ff[i] <= INIT_HASH[i];
      end else begin
         st_ff <= st_in;
         unique case (st_ff)
            BK_IDLE: if (q_valid) begin
               dw_ff   <= q_data.data_word;
               nb_ff   <= q_data.byte_count;
               bi_ff   <= '0;
               last_ff <= q_data.last_word;
               bits_ff <= bits_ff + {58'd0, q_data.byte_count, 3'd0};
               pad_ff  <= 1'b0;
               lenblk_ff <= 1'b0;
            end
            BK_LOAD: begin
               // one byte per cycle; start compression on a full block
               if (ld_byte || ld_zero) begin
                  if (ld_byte) begin
                     w_ff[pos_ff[5:2]][5'(31 - 8*pos_ff[1:0]) -: 8] <= cur_byte;
                     nb_ff <= nb_ff - 1'b1;
                     bi_ff <= bi_ff + 1'b1;
                  end else begin
                     w_ff[pos_ff[5:2]][5'(31 - 8*pos_ff[1:0]) -: 8] <= 8'h00;
                  end
                  pos_ff <= pos_ff + 1'b1;
                  if (pos_ff == POS_LAST) begin
                     rnd_ff <= '0;
                     for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
                  end
               end else if (ld_mark) begin
                  w_ff[pos_ff[5:2]][5'(31 - 8*pos_ff[1:0]) -: 8] <= 8'h80;
                  pos_ff <= pos_ff + 1'b1;
                  pad_ff <= 1'b1;
                  if (pos_ff == POS_LAST) begin
                     rnd_ff <= '0;
                     for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
                  end
               end else if (pad_ff) begin
                  // length words go in, final block
                  w_ff[14]  <= bits_ff[63:32];
                  w_ff[15]  <= bits_ff[31:0];
                  pos_ff    <= '0;
                  lenblk_ff <= 1'b1;
                  rnd_ff    <= '0;
                  for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
               end
            end
            BK_ROUND: begin
               if (rnd_ff >= 7'd16) begin
                  for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
                  w_ff[15] <= wnew;
               end
               v_ff[7] <= v_ff[6];
               v_ff[6] <= v_ff[5];
               v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2];
               v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               rnd_ff  <= rnd_ff + 1'b1;
            end
            BK_FOLD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               oi_ff <= '0;
            end
            BK_EMIT: if (rsp_ready) begin
               oi_ff <= oi_ff + 1'b1;
               if (oi_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) h_ff[i] <= INIT_HASH[i];
                  pos_ff  <= '0;
                  bits_ff <= '0;
                  pad_ff  <= 1'b0;
                  lenblk_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/sha256_message_hasher_unit.sv
// SHA-256 message hasher top level: front end, request queue, back end.
// The back end takes a request while idle, packs its message bytes and, after
// the last word, the padding into the block, compresses each block in 64 rounds
// and a fold, and outputs the eight digest words. With a single round unit it
// takes no new request until done with the last. Synchronous reset restores the
// initial hash, clears the byte and bit counters and empties the queue.
`default_nettype none
module sha256_message_hasher_unit
   import shamh_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_data_word,
   input  wire logic [2:0]  req_byte_count,
   input  wire logic        req_last_word,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_digest
);
   logic    fq_valid, fq_ready, qb_valid, qb_ready;
   req_type fq_data, qb_data;

   shamh_front u_front (
      .req_valid, .req_ready, .req_data_word, .req_byte_count, .req_last_word,
      .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data));

   shamh_queue u_queue (
      .clock, .reset,
      .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
      .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data));

   shamh_back u_back (
      .clock, .reset,
      .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
      .rsp_valid, .rsp_ready, .rsp_digest_word, .rsp_word_index, .rsp_last_digest);
endmodule
`default_nettype wire

>>> rtl/core/shamh_checker.sv
// Port-level checker for the SHA-256 message hasher, bound to the top level.
// Depends on shamh_pkg only through the bound module.
`default_nettype none
module shamh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_word_index,
   input wire logic        rsp_last_digest,
   input wire logic [31:0] rsp_digest_word
);
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_digest == (rsp_word_index == 3'd7)))
      else $error("last_digest mismatch");

   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_digest) |=>
         (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest words not consecutive");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_digest_word)))
      else $error("stalled response changed");
endmodule

bind sha256_message_hasher_unit shamh_checker u_shamh_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_word_index,
   .rsp_last_digest, .rsp_digest_word);
`default_nettype wire

>>> tb/tb_top.sv
// Testbench for the SHA-256 message hasher: drives word requests, predicts the
// digest with its own SHA-256 model and checks every digest word. Needs shamh_pkg.
`timescale 1ns / 1ps
module tb_top;
   import shamh_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_data_word;
   logic [2:0]  req_byte_count;
   logic        req_last_word;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_digest;

   sha256_message_hasher_unit dut (.*);

   typedef struct {
      logic [31:0] word;
      logic [2:0]  idx;
      logic        fin;
   } digest_item_type;

   typedef struct {
      logic [31:0] data;
      logic [2:0]  cnt;
      logic        fin;
      logic [31:0] h0;   // typed-in first digest word, 0 = use predictor only
   } stim_row_type;

   localparam logic [31:0] IV_WORDS [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
   localparam logic [31:0] K_TAB [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   // predictor state
   logic [31:0] hash_st [8];
   logic [31:0] blk_words [16];
   int unsigned blk_bytes;
   logic [63:0] bit_len;

   digest_item_type digest_q [$];
   int          mismatches = 0;
   bit          stim_done = 0;
   bit          calm = 0;
   bit          hold_off = 0;

   function automatic logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_blk();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) w[i] = blk_words[i];
      a = hash_st[0]; b = hash_st[1]; c = hash_st[2]; d = hash_st[3];
      e = hash_st[4]; f = hash_st[5]; g = hash_st[6]; h = hash_st[7];
      for (int i = 0; i < 64; i++) begin
         if (i >= 16) begin
            s0 = ror32(w[(i+1)%16], 7) ^ ror32(w[(i+1)%16], 18) ^ (w[(i+1)%16] >> 3);
            s1 = ror32(w[(i+14)%16], 17) ^ ror32(w[(i+14)%16], 19) ^ (w[(i+14)%16] >> 10);
            w[i%16] = w[i%16] + s0 + s1 + w[(i+9)%16];
         end
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
              + K_TAB[i] + w[i%16];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
      hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
   endtask

   task automatic append_byte(logic [7:0] v);
      int sh;
      sh = (3 - (blk_bytes % 4)) * 8;
      blk_words[blk_bytes/4] = (blk_words[blk_bytes/4] & ~(32'hff << sh)) | (32'(v) << sh);
      blk_bytes++;
      if (blk_bytes == 64) begin
         compress_blk();
         blk_bytes = 0;
      end
   endtask

   task automatic hash_restart();
      for (int i = 0; i < 8; i++) hash_st[i] = IV_WORDS[i];
      blk_bytes = 0;
      bit_len = '0;
   endtask

   // absorb one request; on a final word push the eight digest words
   task automatic absorb_word(logic [31:0] data, logic [2:0] cnt, logic fin);
      int n;
      digest_item_type d;
      n = (cnt > 4) ? 4 : cnt;
      for (int i = 0; i < n; i++) append_byte(data[31-8*i -: 8]);
      bit_len += 64'(n * 8);
      if (fin) begin
         append_byte(8'h80);
         while (blk_bytes != 56) append_byte(8'h00);
         blk_words[14] = bit_len[63:32];
         blk_words[15] = bit_len[31:0];
         compress_blk();
         for (int i = 0; i < 8; i++) begin
            d.word = hash_st[i]; d.idx = 3'(i); d.fin = (i == 7);
            digest_q.push_back(d);
         end
         hash_restart();
      end
   endtask

   task automatic report_err(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // response side: random stalls, one long hold-off
   int unsigned stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off) begin
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      digest_item_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_q.size() == 0) begin
            report_err("unexpected digest word", rsp_digest_word, 32'h0);
         end else begin
            e = digest_q.pop_front();
            if (rsp_digest_word !== e.word) report_err("digest_word", rsp_digest_word, e.word);
            if (rsp_word_index !== e.idx) report_err("word_index", 32'(rsp_word_index), 32'(e.idx));
            if (rsp_last_digest !== e.fin) report_err("last_digest", 32'(rsp_last_digest), 32'(e.fin));
         end
      end
   end

   task automatic send_req(logic [31:0] data, logic [2:0] cnt, logic fin);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_word <= data;
      req_byte_count <= cnt;
      req_last_word <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      absorb_word(data, cnt, fin);
   endtask

   // random message: mostly full words, an odd short word, sometimes huge counts
   task automatic send_message(int words);
      logic [2:0] c;
      for (int i = 0; i < words; i++) begin
         c = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
         send_req($urandom, c, 1'b0);
      end
      send_req($urandom, 3'($urandom_range(0, 7)), 1'b1);
   endtask

   stim_row_type dir_tab [10] = '{
      '{32'h0000_0000, 3'd0, 1'b1, 32'he3b0c442},   // empty message
      '{32'h6162_6300, 3'd3, 1'b1, 32'hba7816bf},   // "abc"
      '{32'hffff_ffff, 3'd7, 1'b1, 32'h0},          // count above four
      '{32'h6100_0000, 3'd1, 1'b0, 32'h0},          // short word mid-stream
      '{32'h6263_0000, 3'd2, 1'b0, 32'h0},
      '{32'hdead_beef, 3'd0, 1'b0, 32'h0},          // zero bytes, not last
      '{32'h0000_0000, 3'd4, 1'b1, 32'h0},
      '{32'hffff_ffff, 3'd4, 1'b0, 32'h0},
      '{32'hffff_ffff, 3'd5, 1'b0, 32'h0},
      '{32'hffff_ffff, 3'd6, 1'b1, 32'h0}
   };

   initial begin
      int sent;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_word = '0;
      req_byte_count = '0;
      req_last_word = 1'b0;
      hash_restart();
      for (int i = 0; i < 16; i++) blk_words[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[r]) begin
         if (dir_tab[r].h0 != 0) begin
            send_req(dir_tab[r].data, dir_tab[r].cnt, dir_tab[r].fin);
            if (digest_q[digest_q.size()-8].word !== dir_tab[r].h0)
               report_err("predictor H0", digest_q[digest_q.size()-8].word, dir_tab[r].h0);
         end else begin
            send_req(dir_tab[r].data, dir_tab[r].cnt, dir_tab[r].fin);
         end
      end
      // padding edges: 55 and 56 bytes fill the length field differently
      for (int i = 0; i < 13; i++) send_req($urandom, 3'd4, 1'b0);
      send_req($urandom, 3'd3, 1'b1);
      for (int i = 0; i < 14; i++) send_req($urandom, 3'd4, 1'b0);
      send_req($urandom, 3'd0, 1'b1);

      // long stall on the digest side while requests keep coming
      hold_off = 1;
      fork
         begin
            repeat (600) @(posedge clock);
            hold_off = 0;
         end
         begin
            for (int m = 0; m < 6; m++) send_message($urandom_range(0, 4));
         end
      join

      sent = 0;
      while (sent < 410) begin
         int len;
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 12);
         if (sent > 350) calm = 1;
         send_message(len);
         sent += len + 1;
      end
      req_valid <= 1'b0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (digest_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #4ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> sha256_message_hasher_unit.f
rtl/core/shamh_pkg.sv
rtl/core/shamh_queue.sv
rtl/core/shamh_front.sv
rtl/core/shamh_back.sv
rtl/core/sha256_message_hasher_unit.sv
rtl/core/shamh_checker.sv
tb/tb_top.sv
